// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the ordered array list RTL. Defining
// NO_ASSERTIONS turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define OAL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A trigger in a cycle that implies a consequence in the next cycle.
`define OAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define OAL_ASSERT(lbl, clk, rstn, prop, msg)
`define OAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/oal_pkg.sv =====
// ----------------------------------------------------------------------------
// oal_pkg
// Types and constants shared by the ordered array list and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

  // Default sizing of the list.
  localparam int DepthDef     = 16;
  localparam int ElemWidthDef = 32;

  // Fixed port widths.
  localparam int PosW    = 5;
  localparam int ValW    = 32;
  localparam int CountW  = 5;
  localparam int StatusW = 2;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  // Status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Operation broadcast to every cell for one accepted transaction.
  typedef struct packed {
    logic ins;  // shift up from the index and load the new value
    logic rem;  // shift down from the index
    logic rd;   // drive the value at the index onto the read bus
  } cell_op_t;

endpackage

`default_nettype wire

// ===== design/oal_cell.sv =====
// ----------------------------------------------------------------------------
// oal_cell
// One list slot. Holds one entry and, on an insert or remove, takes its
// value from the neighbor below or above, so the whole row shifts at once.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_cell
  import oal_pkg::*;
#(
  parameter int ELEM_WIDTH = ElemWidthDef,
  parameter int IDX_W      = PosW,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire cell_op_t              op_i,
  input  wire logic [IDX_W-1:0]      idx_i,
  input  wire logic [ELEM_WIDTH-1:0] new_value_i,
  input  wire logic [ELEM_WIDTH-1:0] left_i,
  input  wire logic [ELEM_WIDTH-1:0] right_i,
  output logic      [ELEM_WIDTH-1:0] value_o,
  output logic      [ELEM_WIDTH-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [ELEM_WIDTH-1:0] value_q;
  logic [ELEM_WIDTH-1:0] value_d;
  logic                  at_idx;
  logic                  above_idx;

  assign at_idx    = (idx_i == MyIdx);
  assign above_idx = (idx_i < MyIdx);

  // Next value: shift from the lower neighbor on insert, from the upper
  // neighbor on remove, otherwise hold.
  always_comb begin
    value_d = value_q;
    if (op_i.ins) begin
      if (above_idx) begin
        value_d = left_i;
      end else if (at_idx) begin
        value_d = new_value_i;
      end
    end else if (op_i.rem) begin
      if (above_idx || at_idx) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

  // Only the addressed cell drives the read bus.
  assign rd_o = (op_i.rd && at_idx) ? value_q : '0;

endmodule

`default_nettype wire

// ===== design/ordered_array_list.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list
// Ordered list of up to DEPTH values with append, insert at index, remove at
// index and read at index.
//
// The request channel (in_valid_i / in_ready_o) carries req_type_i,
// position_i and new_value_i. Every transaction produces exactly one result
// transaction on the response channel (out_valid_o / out_ready_i): a status,
// the value read and the entry count after the request.
// The result sits in an output register the cycle after acceptance.
// Throughput is one transaction per cycle while the receiver takes each
// result; the entries live in a row of cells that all shift in the same
// cycle, and the read value is gathered by an OR over the cells.
// in_ready_o is high while the output register is empty or being emptied,
// so a stalled receiver holds back new requests only while a result waits.
// Reset empties the list and the output register; entry contents are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ordered_array_list
  import oal_pkg::*;
#(
  parameter int DEPTH      = DepthDef,
  parameter int ELEM_WIDTH = ElemWidthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [PosW-1:0]    position_i,
  input  wire logic [ValW-1:0]    new_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [StatusW-1:0] status_o,
  output logic      [ValW-1:0]    read_value_o,
  output logic      [CountW-1:0]  entry_count_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  logic [CntW-1:0]    count_q, count_d;
  logic               out_valid_q;
  status_e            status_q, status_d;
  logic [ValW-1:0]    read_value_q, read_value_d;
  logic [CountW-1:0]  count_out_q;

  logic               in_acc;
  req_e               req;
  logic [CmpW-1:0]    pos_c, cnt_c, idx;
  logic               is_full;
  cell_op_t           op;
  logic [ELEM_WIDTH-1:0] elem_in;
  logic [ELEM_WIDTH-1:0] rd_bus;

  logic [ELEM_WIDTH-1:0] cell_val [DEPTH];
  logic [ELEM_WIDTH-1:0] cell_rd  [DEPTH];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign req        = req_e'(req_type_i);
  assign pos_c      = CmpW'(position_i);
  assign cnt_c      = CmpW'(count_q);
  assign is_full    = (count_q == Full);
  assign elem_in    = ELEM_WIDTH'(new_value_i);

  // Request decode: status, target index and the operation for the cells.
  always_comb begin
    status_d = ST_OK;
    idx      = pos_c;
    op       = '0;
    count_d  = count_q;
    unique case (req) inside
      REQ_APPEND, REQ_INSERT: begin
        if (req == REQ_APPEND) begin
          idx = cnt_c;
        end
        if (idx > cnt_c) begin
          status_d = ST_RANGE;
        end else if (is_full) begin
          status_d = ST_FULL;
        end else begin
          op.ins  = in_acc;
          count_d = count_q + CntW'(1);
        end
      end
      REQ_REMOVE: begin
        if (pos_c >= cnt_c) begin
          status_d = ST_RANGE;
        end else begin
          op.rem  = in_acc;
          count_d = count_q - CntW'(1);
        end
      end
      REQ_READ: begin
        if (pos_c >= cnt_c) begin
          status_d = ST_RANGE;
        end else begin
          op.rd = 1'b1;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  // Row of cells; each one looks at its neighbors.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_v;
    logic [ELEM_WIDTH-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = elem_in;
    end else begin : g_mid_lo
      assign left_v = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_mid_hi
      assign right_v = cell_val[g+1];
    end

    oal_cell #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .IDX_W     (CmpW),
      .INDEX     (g)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .idx_i      (idx),
      .new_value_i(elem_in),
      .left_i     (left_v),
      .right_i    (right_v),
      .value_o    (cell_val[g]),
      .rd_o       (cell_rd[g])
    );
  end

  // At most one cell drives a nonzero read value.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  assign read_value_d = ValW'(rd_bus);

  // Entry count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q     <= status_d;
      read_value_q <= read_value_d;
      count_out_q  <= CountW'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = read_value_q;
  assign entry_count_o = count_out_q;

  // The count never passes the capacity.
  `OAL_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= Full, "entry count above capacity")

  // An append to a full list reports full and keeps the count.
  `OAL_ASSERT_NEXT(a_full_append, clk_i, rst_ni, in_acc && is_full && req == REQ_APPEND,
    status_q == ST_FULL && count_q == Full, "append to full list not rejected")

  // A failed request never returns a read value.
  `OAL_ASSERT(a_fail_zero, clk_i, rst_ni, !(out_valid_q && status_q != ST_OK) || read_value_q == '0,
    "nonzero read value on failed request")

  // A successful insert grows the list by one.
  `OAL_ASSERT_NEXT(a_ins_grow, clk_i, rst_ni, in_acc && op.ins,
    count_q == $past(count_q) + CntW'(1), "insert did not grow the list")

endmodule

`default_nettype wire

// ===== sim/ordered_array_list_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_test
// Self-checking testbench for the ordered array list. A behavioral list in
// the testbench tracks every accepted request and queues the result it
// implies. Each result taken from the block is compared field by field with
// the oldest queued one. Directed tests cover the empty and full list, the
// index limits and every request type. A long random run follows, with
// phases that grow, shrink and churn the list. The sender works in bursts
// with gaps, and the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module ordered_array_list_test;
  import oal_pkg::*;

  localparam int ListDepth   = DepthDef;
  localparam int RandomItems = 1900;
  localparam int ReportLimit = 10;
  localparam int DrainGuard  = 100000;

  // One predicted result transaction.
  typedef struct packed {
    status_e           status;
    logic [ValW-1:0]   value;
    logic [CountW-1:0] count;
  } list_result_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_RARELY,
    RX_PERIODIC
  } stall_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         req_type_i;
  logic [PosW-1:0]    position_i;
  logic [ValW-1:0]    new_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [StatusW-1:0] status_o;
  logic [ValW-1:0]    read_value_o;
  logic [CountW-1:0]  entry_count_o;

  // Testbench copy of the list contents.
  logic [ValW-1:0] list_words [ListDepth];
  int unsigned     list_len = 0;

  list_result_t awaited_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left     = 0;
  int unsigned  req_counts [4] = '{0, 0, 0, 0};
  int unsigned  status_counts [3] = '{0, 0, 0};
  int unsigned  peak_len = 0;

  stall_mode_e  stall_mode = RX_ALWAYS;
  int unsigned  stall_left = 0;

  ordered_array_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .new_value_i   (new_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one request to the testbench list and return the result it gives.
  function automatic list_result_t apply_list_request(input req_e kind,
                                                      input logic [PosW-1:0] pos,
                                                      input logic [ValW-1:0] val);
    list_result_t res;
    int unsigned  idx;
    res.status = ST_OK;
    res.value  = '0;
    idx = (kind == REQ_APPEND) ? list_len : int'(pos);
    if (kind == REQ_APPEND || kind == REQ_INSERT) begin
      // The index check comes before the full check.
      if (idx > list_len) begin
        res.status = ST_RANGE;
      end else if (list_len >= ListDepth) begin
        res.status = ST_FULL;
      end else begin
        for (int unsigned i = list_len; i > idx; i--) begin
          list_words[i] = list_words[i-1];
        end
        list_words[idx] = val;
        list_len++;
      end
    end else if (idx >= list_len) begin
      res.status = ST_RANGE;
    end else if (kind == REQ_REMOVE) begin
      for (int unsigned i = idx; i + 1 < list_len; i++) begin
        list_words[i] = list_words[i+1];
      end
      list_len--;
    end else begin
      res.value = list_words[idx];
    end
    res.count = CountW'(list_len);
    req_counts[kind]++;
    status_counts[res.status]++;
    if (list_len > peak_len) begin
      peak_len = list_len;
    end
    return res;
  endfunction

  // Count a failure and report it while the report budget lasts.
  function automatic void note_mismatch(input string what, input logic [ValW-1:0] want,
                                        input logic [ValW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endfunction

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input req_e kind, input logic [PosW-1:0] pos,
                              input logic [ValW-1:0] val);
    pace_sender();
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    position_i  <= pos;
    new_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_results.push_back(apply_list_request(kind, pos, val));
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic wait_for_results();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0 && guard < DrainGuard) begin
      @(posedge clk_i);
      guard++;
    end
    if (awaited_results.size() != 0) begin
      note_mismatch("results never returned", ValW'(awaited_results.size()), '0);
      awaited_results.delete();
    end
  endtask

  // Requests that an empty list must reject.
  task automatic test_empty_list();
    send_request(REQ_READ,   5'd0,  32'h1234_5678);
    send_request(REQ_REMOVE, 5'd0,  32'h0);
    send_request(REQ_INSERT, 5'd1,  32'hDEAD_BEEF);
    send_request(REQ_INSERT, 5'd31, 32'hFFFF_FFFF);
    send_request(REQ_READ,   5'd31, 32'h0);
  endtask

  // Inserts at the front, middle and end, reads and removes.
  task automatic test_edit_and_read();
    send_request(REQ_INSERT, 5'd0,  32'hFFFF_FFFF);
    send_request(REQ_APPEND, 5'd31, 32'h0000_0000);
    send_request(REQ_INSERT, 5'd1,  32'hA5A5_A5A5);
    send_request(REQ_INSERT, 5'd3,  32'h5A5A_5A5A);
    send_request(REQ_INSERT, 5'd0,  32'h0000_0001);
    send_request(REQ_READ,   5'd0,  32'h0);
    send_request(REQ_READ,   5'd4,  32'h0);
    send_request(REQ_READ,   5'd5,  32'h0);
    send_request(REQ_READ,   5'd16, 32'h0);
    send_request(REQ_REMOVE, 5'd2,  32'h0);
    send_request(REQ_REMOVE, 5'd0,  32'h0);
    send_request(REQ_REMOVE, PosW'(list_len - 1), 32'h0);
    send_request(REQ_READ,   5'd0,  32'h0);
    send_request(REQ_READ,   5'd1,  32'h0);
  endtask

  // Fill the list completely, then probe the limits of a full list.
  task automatic test_full_list();
    while (list_len < ListDepth) begin
      send_request(REQ_APPEND, PosW'($urandom_range(0, 31)), $urandom());
    end
    send_request(REQ_APPEND, 5'd0,  32'h1111_1111);
    send_request(REQ_INSERT, 5'd16, 32'h2222_2222);
    send_request(REQ_INSERT, 5'd0,  32'h3333_3333);
    send_request(REQ_INSERT, 5'd17, 32'h4444_4444);
    send_request(REQ_READ,   5'd15, 32'h0);
    send_request(REQ_READ,   5'd16, 32'h0);
    send_request(REQ_REMOVE, 5'd15, 32'h0);
    send_request(REQ_REMOVE, 5'd0,  32'h0);
    send_request(REQ_INSERT, 5'd15, 32'hFFFF_FFFF);
    send_request(REQ_READ,   5'd15, 32'h0);
  endtask

  // One random request; grow_pct sets the share of appends and inserts.
  task automatic random_request(input int unsigned grow_pct);
    req_e            kind;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    int unsigned     pick;
    int unsigned     top;
    pick = $urandom_range(0, 99);
    if (pick < grow_pct) begin
      kind = ($urandom_range(0, 1) != 0) ? REQ_APPEND : REQ_INSERT;
    end else begin
      kind = ($urandom_range(0, 4) < 3) ? REQ_REMOVE : REQ_READ;
    end
    // Mostly legal indexes, some anywhere up to the depth, a few beyond it.
    if (kind == REQ_INSERT || kind == REQ_APPEND) begin
      top = list_len;
    end else begin
      top = (list_len == 0) ? 0 : list_len - 1;
    end
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      pos = PosW'($urandom_range(0, top));
    end else if (pick < 95) begin
      pos = PosW'($urandom_range(0, ListDepth));
    end else begin
      pos = PosW'($urandom_range(0, 31));
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      val = '0;
    end else if (pick < 20) begin
      val = '1;
    end else begin
      val = $urandom();
    end
    send_request(kind, pos, val);
  endtask

  // Random traffic in phases that grow, shrink or churn the list.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned grow_pct;
    int unsigned phase_left;
    grow_pct   = 40;
    phase_left = 0;
    for (int unsigned sent = 0; sent < n_items; sent++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0:       grow_pct = 70;
          1:       grow_pct = 15;
          default: grow_pct = 40;
        endcase
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      if (sent % 500 == 499) begin
        wait_for_results();
      end
      random_request(grow_pct);
    end
  endtask

  // Receiver readiness: each pattern holds for a random stretch.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RX_ALWAYS:   out_ready_i <= 1'b1;
      RX_MOSTLY:   out_ready_i <= ($urandom_range(0, 3) != 0);
      RX_RARELY:   out_ready_i <= ($urandom_range(0, 3) == 0);
      default:     out_ready_i <= stall_left[2];
    endcase
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("result with no request outstanding", '0, ValW'(status_o));
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status) begin
          note_mismatch("status", ValW'(want.status), ValW'(status_o));
        end
        if (read_value_o !== want.value) begin
          note_mismatch("read value", want.value, read_value_o);
        end
        if (entry_count_o !== want.count) begin
          note_mismatch("entry count", ValW'(want.count), ValW'(entry_count_o));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    req_type_i  = REQ_APPEND;
    position_i  = '0;
    new_value_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_edit_and_read();
    wait_for_results();
    test_full_list();
    wait_for_results();
    test_random_traffic(RandomItems);
    wait_for_results();
    repeat (5) @(posedge clk_i);

    $display("Covered %0d appends, %0d inserts, %0d removes, %0d reads; peak fill %0d.",
             req_counts[REQ_APPEND], req_counts[REQ_INSERT],
             req_counts[REQ_REMOVE], req_counts[REQ_READ], peak_len);
    $display("Outcomes: %0d ok, %0d out of range, %0d full; %0d mismatches.",
             status_counts[ST_OK], status_counts[ST_RANGE], status_counts[ST_FULL],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== ordered_array_list.f =====
+incdir+design
design/oal_pkg.sv
design/oal_cell.sv
design/ordered_array_list.sv
sim/ordered_array_list_test.sv
